>>> hw/rtl/assert_macros.svh
// Shared assertion macros for the gate controller checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, clock, rstn, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Whenever the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clock, rstn, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hw/rtl/gmc_pkg.sv
`timescale 1ns / 1ps

package gmc_pkg;

	// Width of the saturating run counters.
	localparam int COUNT_WIDTH = 10;
	// Width of the sample_count register and of the configuration data.
	localparam int SAMPLE_WIDTH = 10;
	localparam int CMP_WIDTH = (COUNT_WIDTH > SAMPLE_WIDTH) ? COUNT_WIDTH : SAMPLE_WIDTH;
	localparam int CFG_INDEX_WIDTH = 1;

	localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_COUNT_RESET = SAMPLE_WIDTH'(35);

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SAMPLE_COUNT = 1'b0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_EDGE_MODE = 1'b1;

	localparam logic [1:0] EDGE_HIGH = 2'd0;
	localparam logic [1:0] EDGE_LOW = 2'd1;
	localparam logic [1:0] EDGE_BOTH = 2'd2;

	localparam logic [1:0] LIMIT_OPEN = 2'b01;
	localparam logic [1:0] LIMIT_CLOSED = 2'b10;

	localparam logic DIR_OPENING = 1'b0;
	localparam logic DIR_CLOSING = 1'b1;

	typedef enum logic [1:0] {
		STAGE_IDLE = 2'd0,
		STAGE_OPENING = 2'd1,
		STAGE_CLOSING = 2'd2
	} stage_t;

	typedef enum logic {
		PHASE_WAIT_HIGH = 1'b0,
		PHASE_WAIT_LOW = 1'b1
	} phase_t;

endpackage

>>> hw/rtl/gmc_debounce.sv
`timescale 1ns / 1ps

module gmc_debounce import gmc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    advance,
	input  logic                    level,
	input  logic [SAMPLE_WIDTH-1:0] sample_count,
	input  logic [1:0]              edge_mode,
	output logic                    pulse
);

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	logic [COUNT_WIDTH-1:0] high_q, low_q;
	logic [COUNT_WIDTH-1:0] high_next, low_next;
	phase_t                 phase_q, phase_next;

	always_comb begin
		if (level) begin
			low_next = '0;
			high_next = (high_q == COUNT_MAX) ? high_q : high_q + 1'b1;
		end else begin
			high_next = '0;
			low_next = (low_q == COUNT_MAX) ? low_q : low_q + 1'b1;
		end
	end

	// The phase flips when the run of the awaited level reaches the threshold exactly.
	always_comb begin
		phase_next = phase_q;
		pulse = 1'b0;
		unique case (phase_q)
			PHASE_WAIT_HIGH: begin
				if (CMP_WIDTH'(high_next) == CMP_WIDTH'(sample_count)) begin
					phase_next = PHASE_WAIT_LOW;
					pulse = (edge_mode != EDGE_LOW);
				end
			end
			PHASE_WAIT_LOW: begin
				if (CMP_WIDTH'(low_next) == CMP_WIDTH'(sample_count)) begin
					phase_next = PHASE_WAIT_HIGH;
					pulse = (edge_mode != EDGE_HIGH);
				end
			end
			default: begin
				phase_next = PHASE_WAIT_HIGH;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_q <= '0;
			low_q <= '0;
			phase_q <= PHASE_WAIT_HIGH;
		end else if (advance) begin
			high_q <= high_next;
			low_q <= low_next;
			phase_q <= phase_next;
		end
	end

endmodule

>>> hw/rtl/gate_motor_controller_debounced.sv
`timescale 1ns / 1ps

// Debounced gate motor controller. Each input transfer is one 1 ms tick with the raw open and
// close button levels and the limit-switch code; each tick yields exactly one result transfer
// with motor run, motor direction and the gate stage held at the start of that tick. An item
// passes through an input register and then a result register on its way to the output, and
// one tick is taken every clock cycle as long as the result side keeps up; a stalled result
// waits in the result register while the next tick sits in the input register. The
// configuration registers (sample_count at index 0, edge_mode at index 1) are written through
// cfg_write_en, cfg_index and cfg_data with no handshake.
module gate_motor_controller_debounced import gmc_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write_en,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [SAMPLE_WIDTH-1:0]    cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       button_open_raw,
	input  logic                       button_close_raw,
	input  logic [1:0]                 limit_switch_bits,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       motor_run,
	output logic                       motor_direction,
	output logic [1:0]                 gate_stage
);

	logic [SAMPLE_WIDTH-1:0] sample_count_q;
	logic [1:0]              edge_mode_q;

	logic       valid_s1;
	logic       open_s1, close_s1;
	logic [1:0] limit_s1;

	logic       out_valid_q;
	logic       motor_run_q, motor_direction_q;
	stage_t     gate_stage_q;

	stage_t     stage_q, stage_next;
	logic       advance;
	logic       open_pulse, close_pulse;
	logic       at_open, at_closed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= SAMPLE_COUNT_RESET;
			edge_mode_q <= EDGE_HIGH;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_SAMPLE_COUNT: sample_count_q <= cfg_data;
				REG_EDGE_MODE:    edge_mode_q <= cfg_data[1:0];
				default:          ;
			endcase
		end
	end

	// The registered tick moves on when the result register is empty or being drained.
	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			open_s1 <= button_open_raw;
			close_s1 <= button_close_raw;
			limit_s1 <= limit_switch_bits;
		end
	end

	gmc_debounce u_debounce_open (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.level        (open_s1),
		.sample_count (sample_count_q),
		.edge_mode    (edge_mode_q),
		.pulse        (open_pulse)
	);

	gmc_debounce u_debounce_close (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.level        (close_s1),
		.sample_count (sample_count_q),
		.edge_mode    (edge_mode_q),
		.pulse        (close_pulse)
	);

	assign at_open = (limit_s1 == LIMIT_OPEN);
	assign at_closed = (limit_s1 == LIMIT_CLOSED);

	always_comb begin
		stage_next = stage_q;
		unique case (stage_q)
			STAGE_OPENING: begin
				if (at_open) stage_next = STAGE_IDLE;
			end
			STAGE_CLOSING: begin
				if (at_closed) stage_next = STAGE_IDLE;
			end
			default: begin
				// Open has priority when both buttons fire in the same tick, unless the gate is already at the open limit.
				if (open_pulse && !at_open) begin
					stage_next = STAGE_OPENING;
				end else if (close_pulse && !at_closed) begin
					stage_next = STAGE_CLOSING;
				end else begin
					stage_next = STAGE_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= STAGE_IDLE;
		end else if (advance) begin
			stage_q <= stage_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			unique case (stage_q)
				STAGE_OPENING: begin
					motor_run_q <= 1'b1;
					motor_direction_q <= DIR_OPENING;
					gate_stage_q <= STAGE_OPENING;
				end
				STAGE_CLOSING: begin
					motor_run_q <= 1'b1;
					motor_direction_q <= DIR_CLOSING;
					gate_stage_q <= STAGE_CLOSING;
				end
				default: begin
					motor_run_q <= 1'b0;
					motor_direction_q <= DIR_OPENING;
					gate_stage_q <= STAGE_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign motor_run = motor_run_q;
	assign motor_direction = motor_direction_q;
	assign gate_stage = gate_stage_q;

endmodule

>>> hw/rtl/gmc_checker.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module gmc_checker import gmc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       motor_run,
	input logic       motor_direction,
	input logic [1:0] gate_stage
);

	logic stage_moving;
	logic [3:0] out_word;
	assign stage_moving = (gate_stage == STAGE_OPENING) || (gate_stage == STAGE_CLOSING);
	assign out_word = {motor_run, motor_direction, gate_stage};

	// A result that is not taken stays on the port unchanged.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_word))
	// The motor runs exactly while the gate is in motion.
	`ASSERT_IMPLIES(a_run_matches_stage, clk, arst_n, out_valid, motor_run == stage_moving)
	// Closing drive only belongs to the closing stage.
	`ASSERT_IMPLIES(a_dir_closing, clk, arst_n, out_valid, motor_direction == (gate_stage == STAGE_CLOSING))
	// The unused stage code never shows up.
	`ASSERT_IMPLIES(a_stage_legal, clk, arst_n, out_valid, stage_moving || (gate_stage == STAGE_IDLE))

endmodule

bind gate_motor_controller_debounced gmc_checker u_gmc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.motor_run       (motor_run),
	.motor_direction (motor_direction),
	.gate_stage      (gate_stage)
);

>>> verif/gate_motor_controller_debounced_tb.sv
`timescale 1ns / 1ps

module gate_motor_controller_debounced_tb;
	import gmc_pkg::*;

	localparam logic [1:0] LIMIT_NONE = 2'b00;
	localparam logic [1:0] LIMIT_BOTH = 2'b11;
	localparam logic [1:0] EDGE_MODE_THREE = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES = 8;

	typedef struct packed {
		logic   run;
		logic   dir;
		stage_t stage;
	} motor_cmd_t;

	typedef struct packed {
		logic                       is_cfg;
		logic [CFG_INDEX_WIDTH-1:0] reg_idx;
		logic [SAMPLE_WIDTH-1:0]    reg_data;
		logic                       open_lvl;
		logic                       close_lvl;
		logic [1:0]                 limits;
		logic                       fixed;
		motor_cmd_t                 want;
	} script_row_t;

	localparam motor_cmd_t IDLE_CMD = {1'b0, DIR_OPENING, STAGE_IDLE};
	localparam motor_cmd_t OPEN_CMD = {1'b1, DIR_OPENING, STAGE_OPENING};
	localparam motor_cmd_t CLOSE_CMD = {1'b1, DIR_CLOSING, STAGE_CLOSING};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write_en = 1'b0;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [SAMPLE_WIDTH-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic button_open_raw = 1'b0;
	logic button_close_raw = 1'b0;
	logic [1:0] limit_switch_bits = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic motor_run;
	logic motor_direction;
	logic [1:0] gate_stage;

	// Shadow copy of the controller state.
	stage_t gate_st;
	phase_t btn_phase [2];
	logic [COUNT_WIDTH-1:0] hi_run [2];
	logic [COUNT_WIDTH-1:0] lo_run [2];
	logic [SAMPLE_WIDTH-1:0] thresh;
	logic [1:0] edge_sel;
	logic [1:0] rest_pos = LIMIT_CLOSED;

	motor_cmd_t due_motor_cmds [$];
	script_row_t script [$];

	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	int stall_left = 0;
	int idle_cycles = 0;
	int fault_count = 0;
	int ticks_sent = 0;
	int cmds_checked = 0;
	int settings_used = 0;
	int gate_runs = 0;

	logic in_fire_s = 1'b0;
	logic out_fire_s = 1'b0;
	motor_cmd_t seen_cmd;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	gate_motor_controller_debounced i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.button_open_raw(button_open_raw),
		.button_close_raw(button_close_raw),
		.limit_switch_bits(limit_switch_bits),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.motor_run(motor_run),
		.motor_direction(motor_direction),
		.gate_stage(gate_stage)
	);

	function automatic logic debounce_step(int ch, logic lvl);
		logic pulse;
		pulse = 1'b0;
		if (lvl) begin
			lo_run[ch] = '0;
			if (hi_run[ch] != {COUNT_WIDTH{1'b1}}) hi_run[ch] = hi_run[ch] + 1'b1;
		end else begin
			hi_run[ch] = '0;
			if (lo_run[ch] != {COUNT_WIDTH{1'b1}}) lo_run[ch] = lo_run[ch] + 1'b1;
		end
		if (btn_phase[ch] == PHASE_WAIT_HIGH) begin
			if (CMP_WIDTH'(hi_run[ch]) == CMP_WIDTH'(thresh)) begin
				btn_phase[ch] = PHASE_WAIT_LOW;
				pulse = (edge_sel != EDGE_LOW);
			end
		end else if (CMP_WIDTH'(lo_run[ch]) == CMP_WIDTH'(thresh)) begin
			btn_phase[ch] = PHASE_WAIT_HIGH;
			pulse = (edge_sel != EDGE_HIGH);
		end
		return pulse;
	endfunction

	// One tick of the controller; the command reflects the stage held before the tick.
	function automatic motor_cmd_t step_gate(logic open_lvl, logic close_lvl, logic [1:0] limits);
		logic at_open, at_closed, open_p, close_p;
		motor_cmd_t cmd;
		at_open = (limits == LIMIT_OPEN);
		at_closed = (limits == LIMIT_CLOSED);
		close_p = debounce_step(1, close_lvl);
		open_p = debounce_step(0, open_lvl);
		case (gate_st)
			STAGE_OPENING: begin
				cmd = OPEN_CMD;
				if (at_open) gate_st = STAGE_IDLE;
			end
			STAGE_CLOSING: begin
				cmd = CLOSE_CMD;
				if (at_closed) gate_st = STAGE_IDLE;
			end
			default: begin
				cmd = IDLE_CMD;
				if (open_p && !at_open) begin
					gate_st = STAGE_OPENING;
					gate_runs++;
				end else if (close_p && !at_closed) begin
					gate_st = STAGE_CLOSING;
					gate_runs++;
				end else begin
					gate_st = STAGE_IDLE;
				end
			end
		endcase
		return cmd;
	endfunction

	// Limit pins follow the gate: an end is reached now and then while moving, and
	// at rest the pins mostly show the end where the gate last stopped.
	function automatic logic [1:0] pick_limits();
		logic [1:0] lim;
		if (gate_st == STAGE_OPENING || gate_st == STAGE_CLOSING) begin
			if ($urandom_range(0, 5) == 0) begin
				lim = (gate_st == STAGE_OPENING) ? LIMIT_OPEN : LIMIT_CLOSED;
				rest_pos = lim;
			end else if ($urandom_range(0, 4) == 0) begin
				lim = 2'($urandom);
			end else begin
				lim = LIMIT_NONE;
			end
		end else begin
			lim = ($urandom_range(0, 3) != 0) ? rest_pos : 2'($urandom);
		end
		return lim;
	endfunction

	function automatic int idle_len(int pct);
		if ($urandom_range(0, 99) >= pct) return 0;
		return ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
	endfunction

	function automatic script_row_t row_tick(logic open_lvl, logic close_lvl, logic [1:0] limits,
			logic fixed, motor_cmd_t want);
		script_row_t r;
		r = '0;
		r.open_lvl = open_lvl;
		r.close_lvl = close_lvl;
		r.limits = limits;
		r.fixed = fixed;
		r.want = want;
		return r;
	endfunction

	function automatic script_row_t row_cfg(logic [CFG_INDEX_WIDTH-1:0] idx,
			logic [SAMPLE_WIDTH-1:0] data);
		script_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.reg_idx = idx;
		r.reg_data = data;
		return r;
	endfunction

	task automatic flag_field(string name, logic [1:0] want_v, logic [1:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
			fault_count++;
		end
	endtask

	// Offers one tick and returns at the edge where it is transferred, with valid still high.
	task automatic drive_tick(logic open_lvl, logic close_lvl, logic [1:0] limits, logic fixed,
			motor_cmd_t want);
		int gap;
		motor_cmd_t cmd;
		gap = idle_len(send_gap_pct);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		button_open_raw <= open_lvl;
		button_close_raw <= close_lvl;
		limit_switch_bits <= limits;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
		cmd = step_gate(open_lvl, close_lvl, limits);
		due_motor_cmds.push_back(fixed ? want : cmd);
		ticks_sent++;
	endtask

	task automatic auto_tick(logic open_lvl, logic close_lvl);
		drive_tick(open_lvl, close_lvl, pick_limits(), 1'b0, IDLE_CMD);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (due_motor_cmds.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [SAMPLE_WIDTH-1:0] data);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		if (idx == REG_SAMPLE_COUNT)
			thresh = data;
		else
			edge_sel = data[1:0];
		@(posedge clk);
	endtask

	// Only the low two bits of the data belong to the edge mode; the rest is sometimes junk.
	task automatic set_levels(logic [SAMPLE_WIDTH-1:0] count, logic [1:0] mode);
		logic [SAMPLE_WIDTH-1:0] mode_word;
		drain();
		mode_word = $urandom_range(0, 1) ? SAMPLE_WIDTH'($urandom) : '0;
		mode_word[1:0] = mode;
		write_reg(REG_SAMPLE_COUNT, count);
		write_reg(REG_EDGE_MODE, mode_word);
		settings_used++;
	endtask

	// A press that bounces, holds for about the threshold, then bounces on release.
	task automatic press(logic use_open, logic use_close, int thr);
		int n;
		logic lvl;
		repeat ($urandom_range(0, 3)) begin
			lvl = 1'($urandom);
			auto_tick(use_open & lvl, use_close & lvl);
		end
		if (thr == 0)
			n = $urandom_range(1, 8);
		else if (thr > 1 && $urandom_range(0, 5) == 0)
			n = thr - 1;
		else
			n = thr + $urandom_range(0, 3);
		repeat (n) auto_tick(use_open, use_close);
		repeat ($urandom_range(0, 3)) begin
			lvl = 1'($urandom);
			auto_tick(use_open & lvl, use_close & lvl);
		end
		n = (thr == 0) ? $urandom_range(1, 8) : thr + $urandom_range(0, 3);
		repeat (n) auto_tick(1'b0, 1'b0);
	endtask

	task automatic run_phase(int thr, logic [1:0] mode, int budget, int s_pct, int r_pct);
		int stop_at;
		int kind;
		set_levels(SAMPLE_WIDTH'(thr), mode);
		send_gap_pct = s_pct;
		recv_stall_pct = r_pct;
		stop_at = ticks_sent + budget;
		while (ticks_sent < stop_at) begin
			kind = $urandom_range(0, 9);
			if (kind <= 2)
				press(1'b1, 1'b0, thr);
			else if (kind <= 4)
				press(1'b0, 1'b1, thr);
			else if (kind == 5)
				press(1'b1, 1'b1, thr);
			else if (kind <= 7)
				repeat ($urandom_range(1, 6)) auto_tick(1'($urandom), 1'($urandom));
			else
				repeat ($urandom_range(1, 4)) auto_tick(1'b0, 1'b0);
		end
	endtask

	always @(negedge clk) begin
		in_fire_s = in_valid && in_ready;
		out_fire_s = out_valid && out_ready;
		seen_cmd = {motor_run, motor_direction, gate_stage};
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_fire_s) begin
				if (due_motor_cmds.size() == 0) begin
					$display("%0t: result transfer with nothing pending, actual run=%0d dir=%0d stage=%0d",
						$time, seen_cmd.run, seen_cmd.dir, seen_cmd.stage);
					fault_count++;
				end else begin
					motor_cmd_t want;
					want = due_motor_cmds.pop_front();
					flag_field("motor_run", 2'(want.run), 2'(seen_cmd.run));
					flag_field("motor_direction", 2'(want.dir), 2'(seen_cmd.dir));
					flag_field("gate_stage", want.stage, seen_cmd.stage);
					cmds_checked++;
				end
			end
			if (in_fire_s || out_fire_s)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d results outstanding",
					$time, idle_cycles, due_motor_cmds.size());
				$display("gate_motor_controller_debounced_tb: FAIL");
				$finish;
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			stall_left = idle_len(recv_stall_pct);
			out_ready <= (stall_left == 0);
		end
	end

	initial begin
		int k;
		gate_st = STAGE_IDLE;
		btn_phase[0] = PHASE_WAIT_HIGH;
		btn_phase[1] = PHASE_WAIT_HIGH;
		hi_run[0] = '0;
		hi_run[1] = '0;
		lo_run[0] = '0;
		lo_run[1] = '0;
		thresh = SAMPLE_COUNT_RESET;
		edge_sel = EDGE_HIGH;

		// Reset settings first; nothing can be accepted within two ticks.
		script.push_back(row_tick(1'b1, 1'b1, LIMIT_NONE, 1'b1, IDLE_CMD));
		script.push_back(row_tick(1'b0, 1'b0, LIMIT_BOTH, 1'b1, IDLE_CMD));
		script.push_back(row_cfg(REG_SAMPLE_COUNT, SAMPLE_WIDTH'(1)));
		script.push_back(row_cfg(REG_EDGE_MODE, SAMPLE_WIDTH'(EDGE_HIGH)));
		// Open, run, stop at the open limit.
		script.push_back(row_tick(1'b1, 1'b0, LIMIT_NONE, 1'b1, IDLE_CMD));
		script.push_back(row_tick(1'b1, 1'b0, LIMIT_NONE, 1'b1, OPEN_CMD));
		script.push_back(row_tick(1'b0, 1'b0, LIMIT_OPEN, 1'b1, OPEN_CMD));
		script.push_back(row_tick(1'b0, 1'b0, LIMIT_OPEN, 1'b1, IDLE_CMD));
		// Presses for the end already reached do nothing.
		script.push_back(row_tick(1'b1, 1'b0, LIMIT_OPEN, 1'b1, IDLE_CMD));
		script.push_back(row_tick(1'b0, 1'b0, LIMIT_OPEN, 1'b1, IDLE_CMD));
		script.push_back(row_tick(1'b0, 1'b1, LIMIT_CLOSED, 1'b1, IDLE_CMD));
		script.push_back(row_tick(1'b0, 1'b0, LIMIT_NONE, 1'b1, IDLE_CMD));
		// Both buttons at once: open wins, limit code three is no end.
		script.push_back(row_tick(1'b1, 1'b1, LIMIT_NONE, 1'b1, IDLE_CMD));
		script.push_back(row_tick(1'b0, 1'b0, LIMIT_BOTH, 1'b1, OPEN_CMD));
		script.push_back(row_tick(1'b0, 1'b0, LIMIT_OPEN, 1'b1, OPEN_CMD));
		// Both buttons at the open end: close takes over.
		script.push_back(row_tick(1'b1, 1'b1, LIMIT_OPEN, 1'b1, IDLE_CMD));
		script.push_back(row_tick(1'b0, 1'b0, LIMIT_OPEN, 1'b1, CLOSE_CMD));
		script.push_back(row_tick(1'b0, 1'b0, LIMIT_CLOSED, 1'b1, CLOSE_CMD));
		script.push_back(row_tick(1'b0, 1'b0, LIMIT_CLOSED, 1'b1, IDLE_CMD));
		// Edge mode three, then a zero sample count.
		script.push_back(row_cfg(REG_SAMPLE_COUNT, SAMPLE_WIDTH'(2)));
		script.push_back(row_cfg(REG_EDGE_MODE, SAMPLE_WIDTH'(EDGE_MODE_THREE)));
		script.push_back(row_tick(1'b1, 1'b0, LIMIT_NONE, 1'b0, IDLE_CMD));
		script.push_back(row_tick(1'b1, 1'b0, LIMIT_NONE, 1'b0, IDLE_CMD));
		script.push_back(row_tick(1'b0, 1'b0, LIMIT_NONE, 1'b0, IDLE_CMD));
		script.push_back(row_tick(1'b0, 1'b0, LIMIT_NONE, 1'b0, IDLE_CMD));
		script.push_back(row_tick(1'b0, 1'b1, LIMIT_NONE, 1'b0, IDLE_CMD));
		script.push_back(row_tick(1'b0, 1'b1, LIMIT_CLOSED, 1'b0, IDLE_CMD));
		script.push_back(row_cfg(REG_SAMPLE_COUNT, SAMPLE_WIDTH'(0)));
		script.push_back(row_cfg(REG_EDGE_MODE, SAMPLE_WIDTH'(EDGE_BOTH)));
		script.push_back(row_tick(1'b1, 1'b1, LIMIT_OPEN, 1'b0, IDLE_CMD));
		script.push_back(row_tick(1'b0, 1'b0, LIMIT_OPEN, 1'b0, IDLE_CMD));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].is_cfg) begin
				drain();
				write_reg(script[i].reg_idx, script[i].reg_data);
			end else begin
				drive_tick(script[i].open_lvl, script[i].close_lvl, script[i].limits,
					script[i].fixed, script[i].want);
			end
		end

		run_phase(1, EDGE_HIGH, 100, 0, 0);
		run_phase(2, EDGE_LOW, 100, 30, 30);
		run_phase(3, EDGE_BOTH, 100, 20, 40);
		run_phase(1, EDGE_MODE_THREE, 90, 40, 10);
		run_phase(0, EDGE_BOTH, 60, 30, 30);
		run_phase(int'(SAMPLE_COUNT_RESET), EDGE_HIGH, 120, 10, 10);
		for (k = 0; k < 6; k++)
			run_phase($urandom_range(1, 6), 2'($urandom), 80,
				$urandom_range(0, 2) * 20, $urandom_range(0, 2) * 20);

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d ticks sent under %0d register settings, %0d motor commands compared",
			ticks_sent, settings_used, cmds_checked);
		$display("the gate was set moving %0d times, with every edge mode and stalls on both sides",
			gate_runs);
		if (fault_count == 0 && due_motor_cmds.size() == 0) begin
			$display("gate_motor_controller_debounced_tb: PASS");
		end else begin
			$display("gate_motor_controller_debounced_tb: FAIL");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/gmc_pkg.sv
hw/rtl/gmc_debounce.sv
hw/rtl/gate_motor_controller_debounced.sv
hw/rtl/gmc_checker.sv
verif/gate_motor_controller_debounced_tb.sv
